### hdl/assert_macros.svh
// assertion macros shared by the aggregator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock, off while reset is asserted
`define FSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be true
`define FSA_NEVER(lbl, expr, msg) \
  `FSA_ASSERT(lbl, !(expr), msg)

`endif

### hdl/fsa_pkg.sv
// types and constants of the filtered stream aggregator
package fsa_pkg;

  localparam int unsigned MAX_ITEMS   = 256;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned IN_W        = 32;
  localparam int unsigned SAMPLE_W    = (VALUE_BITS < IN_W) ? VALUE_BITS : IN_W;
  localparam int unsigned RES_W       = 40;
  localparam int unsigned CNT_W       = $clog2(MAX_ITEMS + 1);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned STEP_W      = $clog2(RES_W);

  localparam logic signed [RES_W-1:0] RES_MAX  = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN  = {1'b1, {(RES_W-1){1'b0}}};
  localparam logic signed [RES_W-1:0] MOST_POS =
    RES_W'((64'(1) << (SAMPLE_W - 1)) - 64'(1));
  localparam logic signed [RES_W-1:0] MOST_NEG = ~MOST_POS;

  typedef enum logic [2:0] {
    MODE_NONE  = 3'd0,
    MODE_SUM   = 3'd1,
    MODE_COUNT = 3'd2,
    MODE_AVG   = 3'd3,
    MODE_MIN   = 3'd4,
    MODE_MAX   = 3'd5,
    MODE_FIRST = 3'd6,
    MODE_LAST  = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

  // one closed set, handed from front to back
  typedef struct packed {
    mode_e                   mode;
    logic signed [RES_W-1:0] acc;
    logic [CNT_W-1:0]        sel_cnt;
    logic [CNT_W-1:0]        item_cnt;
    logic                    found;
  } job_t;

endpackage

### hdl/fsa_if.sv
// stream and configuration channel interfaces
interface fsa_in_if;
  import fsa_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] sample_value;
  logic                   selected;
  logic                   end_of_set;
  modport source (output valid, sample_value, selected, end_of_set, input ready);
  modport sink (input valid, sample_value, selected, end_of_set, output ready);
endinterface

interface fsa_out_if;
  import fsa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] aggregate_result;
  logic                    none_selected;
  modport source (output valid, aggregate_result, none_selected, input ready);
  modport sink (input valid, aggregate_result, none_selected, output ready);
endinterface

interface fsa_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  modport source (output valid, mode, input ready);
  modport sink (input valid, mode, output ready);
endinterface

### hdl/fsa_front.sv
// front end: mode register, per-item folding and set closing
`include "assert_macros.svh"

module fsa_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  fsa_in_if.sink          in_i,
  fsa_cfg_if.sink         cfg_i,
  input  logic            full_i,
  output logic            push_o,
  output fsa_pkg::job_t   job_o
);
  import fsa_pkg::*;

  mode_e                   mode_q;
  logic signed [RES_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]        sel_q, sel_d;
  logic [CNT_W-1:0]        item_q, item_d;
  logic                    found_q, found_d;

  logic signed [RES_W-1:0] v;
  logic signed [RES_W:0]   sum_wide;
  logic signed [RES_W-1:0] sum_sat;
  logic signed [RES_W-1:0] acc_f;
  logic [CNT_W-1:0]        sel_f, item_f;
  logic                    found_f;
  logic                    accept;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !full_i;
  assign accept      = in_i.valid && in_i.ready;

  always_comb begin
    v        = {{(RES_W-SAMPLE_W){in_i.sample_value[SAMPLE_W-1]}},
                in_i.sample_value[SAMPLE_W-1:0]};
    sum_wide = {acc_q[RES_W-1], acc_q} + {v[RES_W-1], v};
    if (sum_wide[RES_W] != sum_wide[RES_W-1]) begin
      sum_sat = sum_wide[RES_W] ? RES_MIN : RES_MAX;
    end else begin
      sum_sat = sum_wide[RES_W-1:0];
    end

    acc_f   = acc_q;
    sel_f   = sel_q;
    item_f  = item_q;
    found_f = found_q;
    // items past the set limit are dropped
    if (item_q < CNT_W'(MAX_ITEMS)) begin
      item_f = item_q + CNT_W'(1);
      if (in_i.selected) begin
        sel_f   = sel_q + CNT_W'(1);
        found_f = 1'b1;
        case (mode_q)
          MODE_SUM, MODE_AVG: acc_f = sum_sat;
          MODE_MIN: begin
            if (!found_q || v < acc_q) acc_f = v;
          end
          MODE_MAX: begin
            if (!found_q || v > acc_q) acc_f = v;
          end
          MODE_FIRST: begin
            if (!found_q) acc_f = v;
          end
          MODE_LAST: acc_f = v;
          default: acc_f = acc_q;
        endcase
      end
    end

    push_o = accept && in_i.end_of_set;
    job_o  = '{mode: mode_q, acc: acc_f, sel_cnt: sel_f, item_cnt: item_f,
               found: found_f};

    acc_d   = acc_q;
    sel_d   = sel_q;
    item_d  = item_q;
    found_d = found_q;
    if (accept) begin
      if (in_i.end_of_set) begin
        acc_d   = '0;
        sel_d   = '0;
        item_d  = '0;
        found_d = 1'b0;
      end else begin
        acc_d   = acc_f;
        sel_d   = sel_f;
        item_d  = item_f;
        found_d = found_f;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NONE;
      acc_q   <= '0;
      sel_q   <= '0;
      item_q  <= '0;
      found_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        mode_q <= mode_e'(cfg_i.mode);
      end
      acc_q   <= acc_d;
      sel_q   <= sel_d;
      item_q  <= item_d;
      found_q <= found_d;
    end
  end

  `FSA_NEVER(a_item_limit, item_q > CNT_W'(MAX_ITEMS), "item count past set limit")
  `FSA_NEVER(a_sel_le_item, sel_q > item_q, "selected count exceeds item count")
  `FSA_ASSERT(a_found_sel, found_q == (sel_q != '0), "found flag disagrees with count")

endmodule

### hdl/fsa_queue.sv
// small queue of closed sets between front and back
`include "assert_macros.svh"

module fsa_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fsa_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output fsa_pkg::job_t job_o
);
  import fsa_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QPTR_W'(1);
      if (do_pop) rd_q <= rd_q + QPTR_W'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (QPTR_W+1)'(1);
      end
    end
  end

  `FSA_NEVER(a_cnt_range, cnt_q > (QPTR_W+1)'(QUEUE_DEPTH), "queue count out of range")
  `FSA_ASSERT(a_ptr_gap, (wr_q - rd_q) == cnt_q[QPTR_W-1:0], "queue pointers disagree")

endmodule

### hdl/fsa_back.sv
// back end: result selection, serial average divider and output register
`include "assert_macros.svh"

module fsa_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  fsa_pkg::job_t job_i,
  output logic          pop_o,
  fsa_out_if.source     out_o
);
  import fsa_pkg::*;

  back_state_e             state_q, state_d;
  logic signed [RES_W-1:0] held_q, held_d;
  logic signed [RES_W-1:0] res_q, res_d;
  logic                    none_q, none_d;
  logic                    valid_q, valid_d;
  logic [RES_W-1:0]        dq_q, dq_d;
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic [CNT_W-1:0]        div_q, div_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic                    neg_q, neg_d;
  logic                    dnone_q, dnone_d;

  logic                    out_free;
  logic                    job_none;
  logic signed [RES_W-1:0] direct_res;
  logic [CNT_W:0]          trial;
  logic                    ge;

  assign out_o.valid            = valid_q;
  assign out_o.aggregate_result = res_q;
  assign out_o.none_selected    = none_q;
  assign out_free               = !valid_q || out_o.ready;
  assign job_none               = (job_i.sel_cnt == '0);

  always_comb begin
    case (job_i.mode)
      MODE_SUM:   direct_res = job_none ? '0 : job_i.acc;
      MODE_COUNT: direct_res = RES_W'(job_i.sel_cnt);
      MODE_AVG:   direct_res = '0;
      MODE_MIN:   direct_res = job_i.found ? job_i.acc : MOST_POS;
      MODE_MAX:   direct_res = job_i.found ? job_i.acc : MOST_NEG;
      MODE_FIRST, MODE_LAST: direct_res = job_i.found ? job_i.acc : held_q;
      default:    direct_res = held_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    held_d  = held_q;
    res_d   = res_q;
    none_d  = none_q;
    valid_d = valid_q && !out_o.ready;
    dq_d    = dq_q;
    rem_d   = rem_q;
    div_d   = div_q;
    step_d  = step_q;
    neg_d   = neg_q;
    dnone_d = dnone_q;
    pop_o   = 1'b0;

    // restoring divide step on magnitudes
    trial = {rem_q, dq_q[RES_W-1]};
    ge    = (trial >= {1'b0, div_q});

    case (state_q)
      BK_IDLE: begin
        if (!empty_i && out_free) begin
          pop_o = 1'b1;
          if (job_i.mode == MODE_AVG && !job_none && job_i.item_cnt != '0) begin
            neg_d   = job_i.acc[RES_W-1];
            dq_d    = job_i.acc[RES_W-1] ? (~job_i.acc + RES_W'(1)) : job_i.acc;
            rem_d   = '0;
            div_d   = job_i.item_cnt;
            step_d  = '0;
            dnone_d = job_none;
            state_d = BK_DIV;
          end else begin
            res_d   = direct_res;
            held_d  = direct_res;
            none_d  = job_none;
            valid_d = 1'b1;
          end
        end
      end
      BK_DIV: begin
        rem_d = ge ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
        dq_d  = {dq_q[RES_W-2:0], ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(RES_W - 1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          res_d   = neg_q ? (~dq_q + RES_W'(1)) : dq_q;
          held_d  = neg_q ? (~dq_q + RES_W'(1)) : dq_q;
          none_d  = dnone_q;
          valid_d = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      held_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    none_q  <= none_d;
    dq_q    <= dq_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
    step_q  <= step_d;
    neg_q   <= neg_d;
    dnone_q <= dnone_d;
  end

  `FSA_ASSERT(a_div_nonzero, (state_q == BK_DIV) |-> (div_q != '0), "divide by zero")
  `FSA_ASSERT(a_rem_below, (state_q == BK_DIV) |-> (rem_q < div_q), "remainder not below divisor")
  `FSA_NEVER(a_pop_busy, pop_o && (state_q != BK_IDLE), "queue read while divider busy")

endmodule

### hdl/filtered_stream_aggregator_unit.sv
// Filtered stream aggregator. Samples (signed Q16.16) stream in at one transaction per
// cycle while the queue is not full; each is folded into a running sum, count, min, max,
// first or last value under the current mode, and the transaction flagged end_of_set
// closes the set and yields one result with a none_selected flag. Closed sets pass
// through a 4-entry queue to the back end, so the input keeps flowing while results
// are finished. The back end loads most results straight into the output register;
// average instead runs a bit-serial restoring divider, then loads the output register.
// The divider and the queue absorb five short sets under average, and a sixth arriving
// while they are busy stalls the input. Items past the first 256 of a set are ignored
// apart from their end flag. The mode register is written through the cfg channel; the
// user must write it only while the block is idle; the block does not enforce this.
module filtered_stream_aggregator_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  fsa_in_if.sink    in_i,
  fsa_cfg_if.sink   cfg_i,
  fsa_out_if.source out_o
);
  import fsa_pkg::*;

  logic push, full, pop, empty;
  job_t job_in, job_out;

  fsa_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  fsa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_out)
  );

  fsa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (job_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

### tb/aggregate_checker.sv
// checker: predicts each set's aggregate from observed transactions and compares results
module aggregate_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [fsa_pkg::IN_W-1:0]  sample_value_i,
  input  logic                      selected_i,
  input  logic                      end_of_set_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [2:0]                cfg_mode_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [fsa_pkg::RES_W-1:0] aggregate_result_i,
  input  logic                      none_selected_i,
  input  logic                      end_check_i,
  output int                        pending_o,
  output int                        checked_o,
  output int                        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fsa_pkg::*;

  localparam longint AGG_TOP = (longint'(1) <<< (RES_W - 1)) - 1;
  localparam longint AGG_BOTTOM = -AGG_TOP - 1;
  localparam logic signed [RES_W-1:0] SAMPLE_TOP =
    RES_W'((longint'(1) <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [RES_W-1:0] SAMPLE_BOTTOM = ~SAMPLE_TOP;

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic                    nothing_sel;
  } aggregate_t;

  mode_e                   cur_mode;
  logic signed [RES_W-1:0] run_acc;
  logic signed [RES_W-1:0] last_result;
  int unsigned             sel_seen;
  int unsigned             items_seen;
  bit                      found_any;
  bit                      end_seen;
  aggregate_t              expected_aggregates[$];

  task automatic report_mismatch(string msg);
    if (fail_count_o < 50) $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  function automatic logic signed [RES_W-1:0] add_clamped(logic signed [RES_W-1:0] a,
                                                          logic signed [RES_W-1:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > AGG_TOP) s = AGG_TOP;
    if (s < AGG_BOTTOM) s = AGG_BOTTOM;
    return RES_W'(s);
  endfunction

  task automatic fold_sample(logic [IN_W-1:0] raw, logic sel, logic last);
    logic signed [SAMPLE_W-1:0] narrow;
    logic signed [RES_W-1:0]    v;
    logic signed [RES_W-1:0]    res;
    logic                       nothing;
    aggregate_t                 closed;
    narrow = raw[SAMPLE_W-1:0];
    v = narrow;
    // items past the per-set limit only contribute their end flag
    if (items_seen < MAX_ITEMS) begin
      items_seen++;
      if (sel) begin
        sel_seen++;
        case (cur_mode)
          MODE_SUM, MODE_AVG: run_acc = add_clamped(run_acc, v);
          MODE_MIN: if (!found_any || v < run_acc) run_acc = v;
          MODE_MAX: if (!found_any || v > run_acc) run_acc = v;
          MODE_FIRST: if (!found_any) run_acc = v;
          MODE_LAST: run_acc = v;
          default: ;
        endcase
        found_any = 1'b1;
      end
    end
    if (last) begin
      nothing = (sel_seen == 0);
      case (cur_mode)
        MODE_SUM: res = nothing ? '0 : run_acc;
        MODE_COUNT: res = RES_W'(sel_seen);
        MODE_AVG: begin
          if (nothing || items_seen == 0) res = '0;
          else res = RES_W'(longint'(run_acc) / longint'(items_seen));
        end
        MODE_MIN: res = found_any ? run_acc : SAMPLE_TOP;
        MODE_MAX: res = found_any ? run_acc : SAMPLE_BOTTOM;
        MODE_FIRST, MODE_LAST: res = found_any ? run_acc : last_result;
        default: res = last_result;
      endcase
      last_result = res;
      closed.value = res;
      closed.nothing_sel = nothing;
      expected_aggregates = {expected_aggregates, closed};
      run_acc = '0;
      sel_seen = 0;
      items_seen = 0;
      found_any = 1'b0;
    end
  endtask

  task automatic check_result();
    aggregate_t want;
    if (expected_aggregates.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with no set closed",
                                $signed(aggregate_result_i)));
      return;
    end
    want = expected_aggregates.pop_front();
    checked_o++;
    if (aggregate_result_i !== want.value)
      report_mismatch($sformatf("aggregate_result %0d, expected %0d",
                                $signed(aggregate_result_i), want.value));
    if (none_selected_i !== want.nothing_sel)
      report_mismatch($sformatf("none_selected %b, expected %b",
                                none_selected_i, want.nothing_sel));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mode = MODE_NONE;
      run_acc = '0;
      last_result = '0;
      sel_seen = 0;
      items_seen = 0;
      found_any = 1'b0;
      end_seen = 1'b0;
      expected_aggregates.delete();
      checked_o = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) cur_mode = mode_e'(cfg_mode_i);
      if (in_valid_i && in_ready_i) fold_sample(sample_value_i, selected_i, end_of_set_i);
      if (out_valid_i && out_ready_i) check_result();
      if (end_check_i && !end_seen) begin
        end_seen = 1'b1;
        if (expected_aggregates.size() != 0)
          report_mismatch($sformatf("%0d expected results never arrived",
                                    expected_aggregates.size()));
      end
    end
    pending_o = expected_aggregates.size();
  end

endmodule

### tb/testbench.sv
// testbench top: clock, reset, stimulus and verdict for the stream aggregator
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fsa_pkg::*;

  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int TOTAL_ITEMS = 1550;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fsa_in_if  in_if ();
  fsa_cfg_if cfg_if ();
  fsa_out_if out_if ();

  int pending;
  int checked;
  int fail_count;
  bit end_check = 1'b0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int sets_sent = 0;

  filtered_stream_aggregator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  aggregate_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_if.valid),
    .in_ready_i         (in_if.ready),
    .sample_value_i     (in_if.sample_value),
    .selected_i         (in_if.selected),
    .end_of_set_i       (in_if.end_of_set),
    .cfg_valid_i        (cfg_if.valid),
    .cfg_ready_i        (cfg_if.ready),
    .cfg_mode_i         (cfg_if.mode),
    .out_valid_i        (out_if.valid),
    .out_ready_i        (out_if.ready),
    .aggregate_result_i (out_if.aggregate_result),
    .none_selected_i    (out_if.none_selected),
    .end_check_i        (end_check),
    .pending_o          (pending),
    .checked_o          (checked),
    .fail_count_o       (fail_count)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    bit hold_used;
    stall_left = 0;
    hold_left = 0;
    hold_used = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (no_idle) begin
        out_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6, 7: return 32'($urandom_range(0, 2000)) - 32'd1000;
      8: return 32'h7FFF_FFFF;
      default: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'hFFFF_FFFF;
    endcase
  endfunction

  // starts and ends at a falling edge; valid stays high between back-to-back transactions
  task automatic push_sample(logic [31:0] value, logic sel, logic last);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.sample_value <= value;
    in_if.selected <= sel;
    in_if.end_of_set <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    if (last) sets_sent++;
  endtask

  task automatic send_set(int len, int sel_pct, bit use_fixed, logic [31:0] fixed_val);
    logic [31:0] value;
    for (int i = 0; i < len; i++) begin
      value = use_fixed ? fixed_val : pick_value();
      push_sample(value, $urandom_range(0, 99) < sel_pct, i == len - 1);
    end
  endtask

  // mode is only changed once every result is out and the back end has settled
  task automatic write_mode(mode_e m);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.mode <= m;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic int pick_sel_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 35;
      2: return 75;
      default: return 100;
    endcase
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 40);
    return $urandom_range(1, 8);
  endfunction

  initial begin
    int phase;
    int wait_cnt;
    phase = 0;
    wait_cnt = 0;
    in_if.valid = 1'b0;
    in_if.sample_value = '0;
    in_if.selected = 1'b0;
    in_if.end_of_set = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.mode = MODE_NONE;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // mode none straight out of reset repeats the held value
    push_sample(32'h1234_5678, 1'b1, 1'b1);
    push_sample(32'h0000_0042, 1'b0, 1'b1);

    write_mode(MODE_SUM);
    push_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
    push_sample(32'h8000_0000, 1'b1, 1'b0);
    push_sample(32'h0000_0001, 1'b1, 1'b1);
    push_sample(32'h0000_0005, 1'b0, 1'b1);

    write_mode(MODE_COUNT);
    push_sample(32'hDEAD_BEEF, 1'b1, 1'b0);
    push_sample(32'h0BAD_F00D, 1'b0, 1'b0);
    push_sample(32'h0000_0000, 1'b1, 1'b1);

    // average divides by all items and truncates toward zero
    write_mode(MODE_AVG);
    push_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
    push_sample(32'h0000_0000, 1'b0, 1'b1);
    push_sample(32'hFFFF_FFF9, 1'b1, 1'b0);
    push_sample(32'h0000_0000, 1'b0, 1'b1);
    push_sample(32'h0000_0003, 1'b0, 1'b1);

    write_mode(MODE_MIN);
    push_sample(32'h0000_0005, 1'b1, 1'b0);
    push_sample(32'h8000_0000, 1'b1, 1'b1);
    push_sample(32'h0000_0009, 1'b0, 1'b1);

    write_mode(MODE_MAX);
    push_sample(32'hFFFF_FFFB, 1'b1, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_sample(32'h8000_0000, 1'b1, 1'b1);
    push_sample(32'h0000_0009, 1'b0, 1'b1);

    write_mode(MODE_FIRST);
    push_sample(32'h0000_1111, 1'b0, 1'b0);
    push_sample(32'hAAAA_AAAA, 1'b1, 1'b0);
    push_sample(32'h5555_5555, 1'b1, 1'b1);
    push_sample(32'h0000_2222, 1'b0, 1'b1);

    write_mode(MODE_LAST);
    push_sample(32'h5555_5555, 1'b1, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b1, 1'b1);
    push_sample(32'h0000_3333, 1'b0, 1'b1);

    // mode switched while a set is open
    write_mode(MODE_SUM);
    push_sample(32'h0000_0064, 1'b1, 1'b0);
    push_sample(32'h0000_00C8, 1'b1, 1'b0);
    write_mode(MODE_MAX);
    push_sample(32'h0000_0032, 1'b1, 1'b1);

    // long output hold while short averaged sets keep coming, filling the queue
    write_mode(MODE_AVG);
    hold_req = 1'b1;
    for (int s = 0; s < 25; s++) send_set($urandom_range(1, 2), 100, 1'b0, '0);

    // sets running past the item limit, the first two at the sample extremes
    write_mode(MODE_SUM);
    send_set(MAX_ITEMS + 4, 100, 1'b1, 32'h7FFF_FFFF);
    write_mode(MODE_AVG);
    send_set(MAX_ITEMS + 40, 100, 1'b1, 32'h8000_0000);
    write_mode(MODE_COUNT);
    send_set(MAX_ITEMS + 1, 60, 1'b0, '0);

    while (items_sent < TOTAL_ITEMS - 70) begin
      write_mode(mode_e'(3'(phase)));
      phase++;
      repeat ($urandom_range(3, 12)) send_set(pick_len(), pick_sel_pct(), 1'b0, '0);
    end

    // last stretch runs with no idling on either side
    no_idle = 1'b1;
    write_mode(mode_e'(3'($urandom_range(0, 7))));
    while (items_sent < TOTAL_ITEMS) send_set(pick_len(), pick_sel_pct(), 1'b0, '0);
    in_if.valid <= 1'b0;

    while (pending != 0 && wait_cnt < 20000) begin
      @(negedge clk_i);
      wait_cnt++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    end_check = 1'b1;
    @(negedge clk_i);

    $display("run: %0d samples in %0d sets, %0d results checked, all eight modes",
             items_sent, sets_sent, checked);
    $display("run: sets past the %0d-item limit, mid-set mode change, %0d-cycle result hold",
             MAX_ITEMS, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/fsa_pkg.sv
hdl/fsa_if.sv
hdl/fsa_front.sv
hdl/fsa_queue.sv
hdl/fsa_back.sv
hdl/filtered_stream_aggregator_unit.sv
tb/aggregate_checker.sv
tb/testbench.sv
